// ----- sv/ptdp_pkg.sv -----
// shared types, constants and helpers of the position trigger delay predictor
package ptdp_pkg;

  localparam int HistDepth = 16;
  localparam int HistAw    = $clog2(HistDepth);

  localparam int PosW    = 32;
  localparam int OpW     = 2;
  localparam int LbW     = 4;
  localparam int AdjW    = 16;
  localparam int DlyW    = 16;
  localparam int CfgIdxW = 3;
  localparam int SpanW   = 11;
  localparam int ADistW  = 25;
  localparam int NumW    = 31;
  localparam int CntW    = $clog2(NumW + 1);

  localparam int SamplePeriod = 125;
  localparam int CommLatency  = 131;
  localparam logic [PosW-1:0] NoTrigger    = 32'h7FFF_FFFF;
  localparam logic [DlyW-1:0] MaxDelayLow  = 16'hFFFF;
  localparam logic [DlyW-1:0] OffDelayHigh = 16'h7FFF;

  // largest distance magnitude whose scaled value stays below the no-trigger code
  localparam logic [ADistW-1:0] MaxDist [16] = '{
    ADistW'(NoTrigger / (SamplePeriod * 1)),  ADistW'(NoTrigger / (SamplePeriod * 2)),
    ADistW'(NoTrigger / (SamplePeriod * 3)),  ADistW'(NoTrigger / (SamplePeriod * 4)),
    ADistW'(NoTrigger / (SamplePeriod * 5)),  ADistW'(NoTrigger / (SamplePeriod * 6)),
    ADistW'(NoTrigger / (SamplePeriod * 7)),  ADistW'(NoTrigger / (SamplePeriod * 8)),
    ADistW'(NoTrigger / (SamplePeriod * 9)),  ADistW'(NoTrigger / (SamplePeriod * 10)),
    ADistW'(NoTrigger / (SamplePeriod * 11)), ADistW'(NoTrigger / (SamplePeriod * 12)),
    ADistW'(NoTrigger / (SamplePeriod * 13)), ADistW'(NoTrigger / (SamplePeriod * 14)),
    ADistW'(NoTrigger / (SamplePeriod * 15)), ADistW'(NoTrigger / (SamplePeriod * 16))
  };

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_CTRL  = 2'd1,
    OP_PRIME = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIG     = 3'd0,
    CFG_REV      = 3'd1,
    CFG_LOOKBACK = 3'd2,
    CFG_ADJUST   = 3'd3,
    CFG_MANUAL   = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DSTART,
    ST_DWAIT,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [HistAw-1:0] rd_addr;
    logic              wr_en;
    logic [HistAw-1:0] wr_addr;
    logic [PosW-1:0]   wr_data;
    logic              prime_en;
  } hist_req_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [PosW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [DlyW-1:0] delay_low;
    logic [DlyW-1:0] delay_high;
    logic            low_written;
    logic            high_written;
    logic            fired;
  } res_t;

  function automatic logic [SpanW-1:0] span_of(input logic [LbW-1:0] lb);
    return SpanW'(SamplePeriod) * (SpanW'(lb) + SpanW'(1));
  endfunction

  // lookback folded into the ring, small constant table
  function automatic logic [HistAw-1:0] lb_mod(input logic [LbW-1:0] lb);
    logic [HistAw-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (lb == LbW'(i)) begin
        r = HistAw'(i % HistDepth);
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/ptdp_if.sv -----
// request channel interfaces of the position trigger delay predictor
interface ptdp_in_if import ptdp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         opcode;
  logic signed [PosW-1:0] position;
  logic                   enable_bit;
  logic                   manual_mode_bit;

  modport source (output valid, opcode, position, enable_bit, manual_mode_bit, input ready);
  modport sink (input valid, opcode, position, enable_bit, manual_mode_bit, output ready);
endinterface

interface ptdp_out_if import ptdp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [DlyW-1:0] delay_low;
  logic [DlyW-1:0] delay_high;
  logic            low_written;
  logic            high_written;
  logic            fired;

  modport source (output valid, delay_low, delay_high, low_written, high_written, fired,
                  input ready);
  modport sink (input valid, delay_low, delay_high, low_written, high_written, fired,
                output ready);
endinterface

interface ptdp_cfg_if import ptdp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [PosW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/ptdp_hist.sv -----
// position history ring: synchronous memory with per-entry valid bits and prime value
module ptdp_hist import ptdp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hist_req_t       req_i,
  output logic [PosW-1:0] rd_data_o
);

  logic [PosW-1:0]      mem_q [HistDepth];
  logic [PosW-1:0]      rdata_q;
  logic [HistDepth-1:0] vld_q;
  logic                 rd_vld_q;
  logic [PosW-1:0]      prime_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      prime_q  <= '0;
    end else begin
      if (req_i.prime_en) begin
        vld_q   <= '0;
        prime_q <= req_i.wr_data;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // entries not written since the last prime read as the prime value
  assign rd_data_o = rd_vld_q ? rdata_q : prime_q;

endmodule

// ----- sv/ptdp_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module ptdp_div import ptdp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  logic [PosW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [PosW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [PosW:0]   shifted;
  logic            fits;

  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    fits    = shifted >= {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? PosW'(shifted - {1'b0, den_q}) : PosW'(shifted);
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- sv/position_trigger_delay_predictor.sv -----
// top level of the position trigger delay predictor for one trigger table
//
// in_i carries requests: a position sample tick, a control write or a history prime.
// out_o returns exactly one result per request, in request order: the delay words
// written and the fired flag. cfg_i writes the trigger position, direction,
// lookback, on-adjust time and manual delay; it is always ready, and the user must
// write it only while no request is in flight; the block does not enforce this.
// a tick reads the past sample from the history memory in the accept cycle and
// writes the new sample back in the next cycle. a tick that predicts a delay runs a
// bit-serial divider, one quotient bit per cycle over 31 bits, and passes through the
// execute, divider start, divider wait and push states; others only execute and push.
// one request is worked on at a time; the next is taken as soon as the engine is
// idle, even while the previous result still waits in the output register.
// when the receiver stalls, the result holds in the output register and a second
// finished result waits in the engine until the output register frees.
// reset clears the history (all samples read as zero), the ring pointer, the
// channel enable, manual mode, the approach flag and all configuration registers.
module position_trigger_delay_predictor import ptdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptdp_in_if.sink     in_i,
  ptdp_out_if.source  out_o,
  ptdp_cfg_if.sink    cfg_i
);

  state_e state_q, state_d;

  logic [PosW-1:0]   trig_q;
  logic              rev_q;
  logic [LbW-1:0]    lookback_q;
  logic [AdjW-1:0]   adjust_q;
  logic [PosW-1:0]   manual_delay_q;

  op_e               op_q, op_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              en_bit_q, en_bit_d;
  logic              man_bit_q, man_bit_d;

  logic [HistAw-1:0] wp_q, wp_d;
  logic              pos_ready_q, pos_ready_d;
  logic              chan_en_q, chan_en_d;
  logic              manual_q, manual_d;

  logic [NumW-1:0]   num_q, num_d;
  logic [PosW-1:0]   aspeed_q, aspeed_d;
  logic              neg_q, neg_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  hist_req_t         hist_req;
  logic [PosW-1:0]   past;
  div_req_t          div_req;
  logic              div_done;
  logic [NumW-1:0]   quo;

  logic              in_accept;
  logic              out_free;
  logic [HistAw-1:0] lbm;
  logic [HistAw-1:0] ring_idx;
  logic [HistAw-1:0] wp_next;
  logic [PosW-1:0]   trig_dist;
  logic [PosW-1:0]   speed;
  logic [PosW-1:0]   adist;
  logic              ready_now;
  logic              past_trig;
  logic              too_far;
  logic              motion_ok;
  logic [ADistW+SpanW-1:0] prod;
  logic signed [PosW:0] quo_s;
  logic signed [PosW:0] t_s;
  logic signed [PosW:0] half_s;
  logic signed [PosW:0] d_s;

  ptdp_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hist_req),
    .rd_data_o (past)
  );

  ptdp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q         <= '0;
      rev_q          <= 1'b0;
      lookback_q     <= '0;
      adjust_q       <= '0;
      manual_delay_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_e'(cfg_i.index))
        CFG_TRIG:     trig_q         <= cfg_i.data;
        CFG_REV:      rev_q          <= cfg_i.data[0];
        CFG_LOOKBACK: lookback_q     <= cfg_i.data[LbW-1:0];
        CFG_ADJUST:   adjust_q       <= cfg_i.data[AdjW-1:0];
        CFG_MANUAL:   manual_delay_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ring addressing
  assign lbm     = lb_mod(lookback_q);
  assign wp_next = (wp_q == HistAw'(HistDepth - 1)) ? '0 : wp_q + 1'b1;

  always_comb begin
    if (wp_q >= lbm) begin
      ring_idx = wp_q - lbm;
    end else begin
      ring_idx = HistAw'({1'b0, wp_q} + (HistAw + 1)'(HistDepth) - {1'b0, lbm});
    end
  end

  // prediction front end
  assign trig_dist = trig_q - pos_q;
  assign speed     = pos_q - past;
  assign adist     = trig_dist[PosW-1] ? (~trig_dist + 1'b1) : trig_dist;
  assign ready_now = pos_ready_q |
                     (rev_q ? (trig_dist[PosW-1] | (trig_dist == '0)) : ~trig_dist[PosW-1]);
  assign past_trig = rev_q ? (~trig_dist[PosW-1] & (trig_dist != '0)) : trig_dist[PosW-1];
  assign too_far   = adist > PosW'(MaxDist[lookback_q]);
  assign motion_ok = rev_q ? speed[PosW-1] : (~speed[PosW-1] & (speed != '0));
  assign prod      = adist[ADistW-1:0] * (ADistW+SpanW)'(span_of(lookback_q));

  // delay back end
  assign quo_s  = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign t_s    = quo_s - $signed((PosW + 1)'(CommLatency));
  assign half_s = t_s[PosW] ? ((t_s + 1) >>> 1) : (t_s >>> 1);
  assign d_s    = half_s - $signed({{(PosW + 1 - AdjW){1'b0}}, adjust_q});

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    en_bit_d    = en_bit_q;
    man_bit_d   = man_bit_q;
    wp_d        = wp_q;
    pos_ready_d = pos_ready_q;
    chan_en_d   = chan_en_q;
    manual_d    = manual_q;
    num_d       = num_q;
    aspeed_d    = aspeed_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    hist_req          = '0;
    hist_req.rd_addr  = ring_idx;
    hist_req.wr_addr  = wp_next;
    hist_req.wr_data  = pos_q;
    div_req           = '0;
    div_req.num       = num_q;
    div_req.den       = aspeed_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d           = op_e'(in_i.opcode);
          pos_d          = in_i.position;
          en_bit_d       = in_i.enable_bit;
          man_bit_d      = in_i.manual_mode_bit;
          hist_req.rd_en = (op_e'(in_i.opcode) == OP_TICK);
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_PUSH;
        unique case (op_q)
          OP_TICK: begin
            hist_req.wr_en = 1'b1;
            wp_d           = wp_next;
            if (chan_en_q && !manual_q) begin
              pos_ready_d = ready_now;
              if (!ready_now || too_far || !motion_ok) begin
                res_d.delay_low   = MaxDelayLow;
                res_d.low_written = 1'b1;
              end else begin
                num_d    = prod[NumW-1:0];
                aspeed_d = speed[PosW-1] ? (~speed + 1'b1) : speed;
                neg_d    = past_trig;
                state_d  = ST_DSTART;
              end
            end
          end
          OP_CTRL: begin
            if (en_bit_q) begin
              if (man_bit_q) begin
                res_d.delay_high = manual_delay_q[2*DlyW-1:DlyW];
                res_d.delay_low  = manual_delay_q[DlyW-1:0];
              end else begin
                res_d.delay_high = '0;
                res_d.delay_low  = MaxDelayLow;
              end
            end else begin
              res_d.delay_high = OffDelayHigh;
              res_d.delay_low  = MaxDelayLow;
              pos_ready_d      = 1'b0;
            end
            res_d.low_written  = 1'b1;
            res_d.high_written = 1'b1;
            manual_d           = man_bit_q;
            chan_en_d          = en_bit_q;
          end
          OP_PRIME: begin
            hist_req.prime_en = 1'b1;
          end
          OP_NONE: ;
          default: ;
        endcase
      end
      ST_DSTART: begin
        div_req.start = 1'b1;
        state_d       = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          res_d             = '0;
          res_d.low_written = 1'b1;
          if (d_s[PosW] || (d_s == '0)) begin
            res_d.fired = 1'b1;
            chan_en_d   = 1'b0;
          end else if (d_s[PosW-1:DlyW] != '0) begin
            res_d.delay_low = MaxDelayLow;
          end else begin
            res_d.delay_low = d_s[DlyW-1:0];
          end
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    op_d_reg: begin
      op_q      <= op_d;
      pos_q     <= pos_d;
      en_bit_q  <= en_bit_d;
      man_bit_q <= man_bit_d;
      num_q     <= num_d;
      aspeed_q  <= aspeed_d;
      neg_q     <= neg_d;
      res_q     <= res_d;
      out_q     <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      pos_ready_q <= 1'b0;
      chan_en_q   <= 1'b0;
      manual_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      pos_ready_q <= pos_ready_d;
      chan_en_q   <= chan_en_d;
      manual_q    <= manual_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.delay_low    = out_q.delay_low;
  assign out_o.delay_high   = out_q.delay_high;
  assign out_o.low_written  = out_q.low_written;
  assign out_o.high_written = out_q.high_written;
  assign out_o.fired        = out_q.fired;

endmodule

// ----- sv/ptdp_checker.sv -----
// port-level checks of the position trigger delay predictor and their binding
module ptdp_checker import ptdp_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [DlyW-1:0] delay_low_i,
  input logic            low_written_i,
  input logic            high_written_i,
  input logic            fired_i
);

  logic [1:0] pending_q, pending_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // result held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // no result without an outstanding request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 2'd0)
    else $error("result without request");

  // at most one request in the engine and one in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many outstanding requests");

  // control write results load both delay words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && high_written_i |-> low_written_i)
    else $error("high word written without low word");

  // a firing tick writes a zero low word only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fired_i |-> low_written_i && !high_written_i && delay_low_i == '0)
    else $error("bad fired result");

endmodule

bind position_trigger_delay_predictor ptdp_checker u_ptdp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .delay_low_i    (out_o.delay_low),
  .low_written_i  (out_o.low_written),
  .high_written_i (out_o.high_written),
  .fired_i        (out_o.fired)
);

// ----- test/position_trigger_delay_predictor_tb.sv -----
// testbench for the position trigger delay predictor: shadow model, directed and random requests
module position_trigger_delay_predictor_tb;
  import ptdp_pkg::*;

  localparam int RandomRequests = 700;
  localparam int MaxCycles      = 400000;
  localparam int EndCycles      = 60;

  logic clk_i;
  logic rst_ni;

  ptdp_in_if  in_if ();
  ptdp_out_if out_if ();
  ptdp_cfg_if cfg_if ();

  position_trigger_delay_predictor uut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // shadow configuration
  logic [PosW-1:0] trig_pos;
  logic            rev_dir;
  logic [LbW-1:0]  lookback;
  logic [AdjW-1:0] adj_time;
  logic [PosW-1:0] manual_dly;

  // shadow table state
  logic [PosW-1:0] ring [HistDepth];
  int              ring_ptr;
  bit              approach_seen;
  bit              chan_en;
  bit              chan_manual;

  res_t pending_delays[$];
  int   errors;
  int   requests_sent;
  int   results_checked;
  int   cycle_count;
  int   src_gap_pct;
  int   snk_stall_pct;

  always #5 clk_i = ~clk_i;

  function automatic longint predict_delay(input logic [PosW-1:0] pos,
                                           input logic [PosW-1:0] past);
    logic signed [PosW-1:0] d32;
    logic signed [PosW-1:0] s32;
    longint distance, speed, dir, span, adist, aspeed, q;
    d32      = trig_pos - pos;
    s32      = pos - past;
    distance = d32;
    speed    = s32;
    dir      = rev_dir ? -1 : 1;
    span     = SamplePeriod * (longint'(lookback) + 1);
    adist    = (distance < 0) ? -distance : distance;
    aspeed   = (speed < 0) ? -speed : speed;
    if (dir * distance >= 0) approach_seen = 1'b1;
    if (!approach_seen || speed == 0) return longint'(NoTrigger);
    if (adist > longint'(NoTrigger) / span) return longint'(NoTrigger);
    if (dir * speed <= 0) return longint'(NoTrigger);
    q = (dir * distance * span) / aspeed;
    return (q - CommLatency) / 2 - longint'(adj_time);
  endfunction

  function automatic res_t next_delay_words(input op_e op, input logic [PosW-1:0] pos,
                                            input logic en, input logic man);
    res_t   r;
    longint d;
    int     idx;
    r = '0;
    case (op)
      OP_TICK: begin
        if (!chan_manual && chan_en) begin
          idx = (ring_ptr + HistDepth - int'(lookback) % HistDepth) % HistDepth;
          d = predict_delay(pos, ring[idx]);
          if (d > longint'(MaxDelayLow)) begin
            d = longint'(MaxDelayLow);
          end else if (d <= 0) begin
            chan_en = 1'b0;
            d = 0;
            r.fired = 1'b1;
          end
          r.delay_low   = DlyW'(d);
          r.low_written = 1'b1;
        end
        ring_ptr = (ring_ptr + 1) % HistDepth;
        ring[ring_ptr] = pos;
      end
      OP_CTRL: begin
        if (!en) begin
          r.delay_high  = OffDelayHigh;
          r.delay_low   = MaxDelayLow;
          approach_seen = 1'b0;
        end else if (man) begin
          r.delay_high = manual_dly[31:16];
          r.delay_low  = manual_dly[15:0];
        end else begin
          r.delay_high = '0;
          r.delay_low  = MaxDelayLow;
        end
        r.low_written  = 1'b1;
        r.high_written = 1'b1;
        chan_en        = en;
        chan_manual    = man;
      end
      OP_PRIME: begin
        foreach (ring[i]) ring[i] = pos;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [DlyW-1:0] want,
                             input logic [DlyW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_delays.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h %h %b%b%b",
                 $time, out_if.delay_low, out_if.delay_high, out_if.low_written,
                 out_if.high_written, out_if.fired);
        errors++;
      end else begin
        want = pending_delays.pop_front();
        check_field("delay_low", want.delay_low, out_if.delay_low);
        check_field("delay_high", want.delay_high, out_if.delay_high);
        check_field("low_written", DlyW'(want.low_written), DlyW'(out_if.low_written));
        check_field("high_written", DlyW'(want.high_written), DlyW'(out_if.high_written));
        check_field("fired", DlyW'(want.fired), DlyW'(out_if.fired));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_delays.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic send_req(input op_e op, input logic [PosW-1:0] pos,
                          input logic en, input logic man);
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.opcode          <= op;
    in_if.position        <= pos;
    in_if.enable_bit      <= en;
    in_if.manual_mode_bit <= man;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    pending_delays.push_back(next_delay_words(op, pos, en, man));
    if (op != OP_NONE) requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_delays.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [PosW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_TRIG:     trig_pos   = value;
      CFG_REV:      rev_dir    = value[0];
      CFG_LOOKBACK: lookback   = value[LbW-1:0];
      CFG_ADJUST:   adj_time   = value[AdjW-1:0];
      CFG_MANUAL:   manual_dly = value;
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [PosW-1:0] trig, input logic rev,
                            input logic [LbW-1:0] lb, input logic [AdjW-1:0] adj,
                            input logic [PosW-1:0] manual);
    wait_idle();
    write_reg(CFG_TRIG, trig);
    write_reg(CFG_REV, PosW'(rev));
    write_reg(CFG_LOOKBACK, PosW'(lb));
    write_reg(CFG_ADJUST, PosW'(adj));
    write_reg(CFG_MANUAL, manual);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_noise();
    op_e             op;
    logic [PosW-1:0] pos;
    op  = op_e'($urandom_range(3));
    pos = $urandom_range(1) ? $urandom : trig_pos + $urandom_range(2000) - 1000;
    send_req(op, pos, $urandom_range(1), $urandom_range(1));
  endtask

  task automatic test_idle_requests();
    send_req(OP_TICK, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_req(OP_NONE, 32'h1234_5678, 1'b1, 1'b1);
    send_req(OP_PRIME, 32'h8000_0000, 1'b0, 1'b0);
  endtask

  task automatic test_control_writes();
    set_config(32'h0, 1'b0, 4'd0, 16'h0, 32'hFFFF_FFFF);
    send_req(OP_CTRL, 32'h0, 1'b1, 1'b1);
    send_req(OP_TICK, 32'h55, 1'b0, 1'b0);
    send_req(OP_CTRL, 32'h0, 1'b1, 1'b0);
    send_req(OP_CTRL, 32'h0, 1'b0, 1'b0);
    send_req(OP_CTRL, 32'h0, 1'b0, 1'b1);
  endtask

  task automatic test_approach_and_fire();
    set_config(32'd1000, 1'b0, 4'd1, 16'h0, 32'h0);
    send_req(OP_PRIME, 32'd0, 1'b0, 1'b0);
    send_req(OP_CTRL, 32'd0, 1'b1, 1'b0);
    // steady approach, stop, reversal, then arrival fires
    send_req(OP_TICK, 32'd100, 1'b0, 1'b0);
    send_req(OP_TICK, 32'd200, 1'b0, 1'b0);
    send_req(OP_TICK, 32'd200, 1'b0, 1'b0);
    send_req(OP_TICK, 32'd150, 1'b0, 1'b0);
    send_req(OP_TICK, 32'd600, 1'b0, 1'b0);
    send_req(OP_TICK, 32'd990, 1'b0, 1'b0);
    send_req(OP_TICK, 32'd1000, 1'b0, 1'b0);
    send_req(OP_TICK, 32'd1100, 1'b0, 1'b0);
  endtask

  task automatic test_extremes();
    // negative direction, longest lookback, distance of -2^31 overflows
    set_config(32'h8000_0000, 1'b1, 4'd15, 16'hFFFF, 32'h0);
    send_req(OP_PRIME, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_req(OP_CTRL, 32'h0, 1'b1, 1'b0);
    send_req(OP_TICK, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_req(OP_TICK, 32'h0, 1'b0, 1'b0);
    send_req(OP_TICK, 32'h8000_0001, 1'b0, 1'b0);
    // speed of -2^31 at the trigger
    set_config(32'h8000_0000, 1'b1, 4'd0, 16'hFFFF, 32'h0);
    send_req(OP_PRIME, 32'h0, 1'b0, 1'b0);
    send_req(OP_CTRL, 32'h0, 1'b1, 1'b0);
    send_req(OP_TICK, 32'h8000_0000, 1'b0, 1'b0);
    send_req(OP_CTRL, 32'h0, 1'b1, 1'b1);
  endtask

  task automatic run_approach();
    logic [PosW-1:0] trig;
    logic [PosW-1:0] cur;
    logic [PosW-1:0] delta;
    logic [AdjW-1:0] adj;
    logic            rev;
    int unsigned     v;
    int unsigned     steps;
    int unsigned     roll;
    trig  = $urandom;
    rev   = $urandom_range(1);
    roll  = $urandom_range(99);
    v     = (roll < 80) ? $urandom_range(3000, 1) : $urandom_range(32'h40_0000, 1);
    steps = $urandom_range(20, 2);
    delta = rev ? PosW'(0) - PosW'(v) : PosW'(v);
    cur   = trig - delta * PosW'(steps);
    roll  = $urandom_range(99);
    if (roll < 70) begin
      adj = $urandom_range(40);
    end else if (roll < 85) begin
      adj = $urandom_range(16'hFFFF);
    end else begin
      adj = $urandom_range(1) ? 16'h0 : 16'hFFFF;
    end
    set_config(trig, rev, LbW'($urandom_range(15)), adj, $urandom);
    send_req(OP_PRIME, cur, 1'b0, 1'b0);
    send_req(OP_CTRL, $urandom, ($urandom_range(9) != 0), ($urandom_range(9) == 0));
    for (int n = 0; n < int'(steps) + 3; n++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_noise();
      end else begin
        if (roll < 10) begin
          cur = cur - delta;
        end else if (roll < 20) begin
          cur = cur + delta + PosW'($urandom_range(v / 4));
        end else if (roll >= 25) begin
          cur = cur + delta;
        end
        send_req(OP_TICK, cur, $urandom_range(1), $urandom_range(1));
      end
    end
  endtask

  task automatic run_noise();
    set_config($urandom, $urandom_range(1), LbW'($urandom_range(15)),
               $urandom_range(16'hFFFF), $urandom);
    repeat (12) send_noise();
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_gap_pct   = 8;
          snk_stall_pct = 65;
        end
        1: begin
          src_gap_pct   = 65;
          snk_stall_pct = 8;
        end
        default: begin
          src_gap_pct   = 0;
          snk_stall_pct = 0;
        end
      endcase
      goal = requests_sent + RandomRequests / 3;
      while (requests_sent < goal) begin
        if ($urandom_range(3) == 0) begin
          run_noise();
        end else begin
          run_approach();
        end
      end
    end
  endtask

  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.opcode          = OP_TICK;
    in_if.position        = '0;
    in_if.enable_bit      = 1'b0;
    in_if.manual_mode_bit = 1'b0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_TRIG;
    cfg_if.data           = '0;
    trig_pos              = '0;
    rev_dir               = 1'b0;
    lookback              = '0;
    adj_time              = '0;
    manual_dly            = '0;
    foreach (ring[i]) ring[i] = '0;
    ring_ptr              = 0;
    approach_seen         = 1'b0;
    chan_en               = 1'b0;
    chan_manual           = 1'b0;
    errors                = 0;
    requests_sent         = 0;
    results_checked       = 0;
    cycle_count           = 0;
    src_gap_pct           = 8;
    snk_stall_pct         = 65;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_requests();
    test_control_writes();
    test_approach_and_fire();
    test_extremes();
    test_random_traffic();

    wait_idle();
    repeat (EndCycles) @(negedge clk_i);
    if (pending_delays.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_delays.size());
      errors++;
    end
    $display("checked %0d results from %0d requests: idle ticks, control writes,",
             results_checked, requests_sent);
    $display("approach and fire, extreme positions, random traffic with stalls on both sides");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ptdp_pkg.sv
sv/ptdp_if.sv
sv/ptdp_hist.sv
sv/ptdp_div.sv
sv/position_trigger_delay_predictor.sv
sv/ptdp_checker.sv
test/position_trigger_delay_predictor_tb.sv
